// ===== rtl/range_max_xor_query_defines.svh =====
// Assertion macros of the range maximum-XOR query block, used by its back end.
`ifndef RANGE_MAX_XOR_QUERY_DEFINES_SVH
`define RANGE_MAX_XOR_QUERY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rmx_pkg.sv =====
// Types and constants of the range maximum-XOR query block.
package rmx_pkg;
    localparam int MAX_ITEMS = 65536;
    localparam int TOP_BIT   = 30;
    localparam int VAL_W     = TOP_BIT + 1;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int POS_W     = 17;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_ERROR
    } t_op_kind;

    typedef struct packed {
        t_cmd              cmd;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  left_pos;
        logic [POS_W-1:0]  right_pos;
        logic [VAL_W-1:0]  key;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] best_xor;
        logic             range_error;
    } t_out_item;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        t_op_kind          kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last;
        logic [VAL_W-1:0]  data;
    } t_op;
endpackage

// ===== rtl/range_max_xor_query.sv =====
// Top level of the range maximum-XOR query block.
// Items are clear, append and query. A query over positions l..r scans the
// stored values one memory read per cycle, since the value memory has a
// single read port. A query with a bad range (left position zero, left
// above right, or right beyond the stored count) is answered through the
// queue and the output register, with the error flag set and a zero result.
// The front checks ranges against its own count and hands appends and
// queries through a two-entry queue to the back, so up to two of them wait
// while a scan runs, and a finished result waits in an output register until
// it is popped.
module range_max_xor_query
    import rmx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);
    logic op_wr;
    t_op  wr_op;
    logic op_full;
    logic op_rd;
    t_op  rd_op;
    logic op_empty;

    // Front end: range checks and item count.
    rmx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_op_wr   (op_wr),
        .o_op      (wr_op),
        .i_op_full (op_full)
    );

    // Queue decoupling the front from the scanning back end.
    rmx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (op_wr),
        .i_wr_op (wr_op),
        .o_full  (op_full),
        .i_rd    (op_rd),
        .o_rd_op (rd_op),
        .o_empty (op_empty)
    );

    // Back end: memory writes, range scans and the result register.
    rmx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (rd_op),
        .i_op_empty (op_empty),
        .o_op_rd    (op_rd),
        .o_result   (o_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );
endmodule

// ===== rtl/rmx_fifo.sv =====
// Two-entry queue of work items between the front and the back.
module rmx_fifo
    import rmx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wr_op,
    output logic o_full,
    input  logic i_rd,
    output t_op  o_rd_op,
    output logic o_empty
);
    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rd_op = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_wr_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_rd && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr && !o_full) - 2'(i_rd && !o_empty);
        end
    end
endmodule

// ===== rtl/rmx_front.sv =====
// Front end: accepts items, tracks the count, checks ranges, issues work.
module rmx_front
    import rmx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_op_wr,
    output t_op      o_op,
    input  logic     i_op_full
);
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic             bad_range;

    assign o_full = i_op_full;
    assign accept = i_push && !i_op_full;

    assign bad_range = (i_item.left_pos == '0) || (i_item.left_pos > i_item.right_pos)
                     || (CNT_W'(i_item.right_pos) > r_count);

    always_comb begin
        n_count      = r_count;
        o_op_wr      = 1'b0;
        o_op.kind    = OP_WRITE;
        o_op.addr    = r_count[ADDR_W-1:0];
        o_op.last    = '0;
        o_op.data    = i_item.value;
        unique case (i_item.cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_APPEND: begin
                if (r_count < CNT_W'(MAX_ITEMS)) begin
                    o_op_wr = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_QUERY: begin
                o_op_wr   = 1'b1;
                o_op.kind = bad_range ? OP_ERROR : OP_QUERY;
                o_op.addr = ADDR_W'(i_item.left_pos - 1'b1);
                o_op.last = ADDR_W'(i_item.right_pos - 1'b1);
                o_op.data = i_item.key;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            o_op_wr = 1'b0;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

// ===== rtl/rmx_back.sv =====
// Back end: value memory, range scan and the result register.
`include "range_max_xor_query_defines.svh"
module rmx_back
    import rmx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    input  logic      i_op_empty,
    output logic      o_op_rd,
    output t_out_item o_result,
    output logic      o_empty,
    input  logic      i_pop
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    logic [VAL_W-1:0]  r_mem [MAX_ITEMS];
    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_last;
    logic [VAL_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_best;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic              r_issued;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              out_free;
    logic              out_load;
    logic              mem_wr;
    logic [VAL_W-1:0]  cand;
    logic [VAL_W-1:0]  n_best;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign cand     = r_key ^ r_rdata;
    assign n_best   = (r_rd_valid && cand > r_best) ? cand : r_best;

    always_comb begin
        o_op_rd = 1'b0;
        if (r_state == ST_IDLE && !i_op_empty) begin
            unique case (i_op.kind)
                OP_WRITE: o_op_rd = 1'b1;
                OP_QUERY: o_op_rd = 1'b1;
                OP_ERROR: o_op_rd = out_free;
                default:  o_op_rd = 1'b0;
            endcase
        end
    end

    assign mem_wr = o_op_rd && (i_op.kind == OP_WRITE);

    // A new result enters the output register only when it is free or being popped.
    assign out_load = (o_op_rd && i_op.kind == OP_ERROR) || (r_state == ST_DONE && out_free);

    // Memory: at most one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[i_op.addr] <= i_op.data;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_valid  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_pop);
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_valid <= 1'b0;
                    if (o_op_rd && i_op.kind == OP_ERROR) begin
                        r_out.best_xor    <= '0;
                        r_out.range_error <= 1'b1;
                    end else if (o_op_rd && i_op.kind == OP_QUERY) begin
                        r_addr   <= i_op.addr;
                        r_last   <= i_op.last;
                        r_key    <= i_op.data;
                        r_best   <= '0;
                        r_issued <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_best <= n_best;
                    if (!r_issued) begin
                        r_rd_valid <= 1'b1;
                        r_rd_last  <= (r_addr == r_last);
                        r_issued   <= (r_addr == r_last);
                        r_addr     <= r_addr + 1'b1;
                    end else begin
                        r_rd_valid <= 1'b0;
                    end
                    if (r_rd_valid && r_rd_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_rd_valid <= 1'b0;
                    if (out_free) begin
                        r_out.best_xor    <= r_best;
                        r_out.range_error <= 1'b0;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `RMX_ASSERT_NOW(a_take_idle, i_clk, i_rst_n, o_op_rd, r_state == ST_IDLE, "work taken while busy")
    `RMX_ASSERT_NOW(a_read_scan, i_clk, i_rst_n, r_rd_valid, r_state == ST_SCAN, "read data outside scan")
    `RMX_ASSERT_NOW(a_write_idle, i_clk, i_rst_n, mem_wr, !r_rd_valid, "write during a scan")
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the range maximum-XOR query block.
`timescale 1ns / 1ps

module tb_top;
    import rmx_pkg::*;

    // A cycle with no accepted item on either side counts toward this limit.
    // The list stays at a few hundred entries at most, so a scan plus the long
    // hold-off of the receiver is far below it.
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    range_max_xor_query DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Handshake state is sampled at the falling edge, where every signal is
    // settled. The posedge processes then act on what happened at the edge.
    logic      item_taken = 1'b0;
    logic      answer_taken = 1'b0;
    t_out_item answer_seen;

    always @(negedge i_clk) begin
        item_taken   = push && !full;
        answer_taken = pop && !empty;
        answer_seen  = o_result;
    end

    // Our own copy of the block's list, updated as items are accepted.
    logic [VAL_W-1:0] list_values [MAX_ITEMS];
    int unsigned      list_count = 0;
    t_out_item        pending_answers [$];
    int               error_count = 0;
    bit               steady_phase = 1'b0;
    int               answers_seen = 0;

    // Applies one item to the list copy. Returns 1 when the item yields an
    // answer, which is then placed in best.
    function automatic bit apply_item(input t_in_item it, output t_out_item best);
        logic [VAL_W-1:0] x;
        best = '0;
        case (it.cmd)
            CMD_CLEAR: begin
                list_count = 0;
                return 1'b0;
            end
            CMD_APPEND: begin
                if (list_count < MAX_ITEMS) begin
                    list_values[ADDR_W'(list_count)] = it.value;
                    list_count++;
                end
                return 1'b0;
            end
            CMD_QUERY: begin
                if (it.left_pos == 0 || it.left_pos > it.right_pos
                        || it.right_pos > list_count) begin
                    best.range_error = 1'b1;
                    return 1'b1;
                end
                for (int p = it.left_pos; p <= it.right_pos; p++) begin
                    x = it.key ^ list_values[ADDR_W'(p - 1)];
                    if (x > best.best_xor) best.best_xor = x;
                end
                return 1'b1;
            end
            default: return 1'b0;  // The unused command changes nothing.
        endcase
    endfunction

    // Offers one item and holds it until taken. Push stays high afterwards,
    // so back-to-back items never lower and raise it in one step.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_ans);
        t_out_item ans;
        bit        has_ans;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!item_taken);
        has_ans = apply_item(it, ans);
        if (has_ans) pending_answers.push_back(typed ? typed_ans : ans);
    endtask

    // Random gaps on the input side, except in the steady stretch.
    task automatic maybe_idle_sender();
        if (!steady_phase && $urandom_range(99) < 7) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    function automatic t_in_item make_item(t_cmd c, logic [VAL_W-1:0] v,
            logic [POS_W-1:0] l, logic [POS_W-1:0] r, logic [VAL_W-1:0] k);
        t_in_item it;
        it.cmd = c;
        it.value = v;
        it.left_pos = l;
        it.right_pos = r;
        it.key = k;
        return it;
    endfunction

    // Directed plan. A row with reps above one appends random values that
    // many times; rows with typed set carry an answer written out by hand.
    typedef struct {
        t_in_item  it;
        int        reps;
        bit        typed;
        t_out_item ans;
    } t_plan_row;

    t_plan_row plan [$];

    function automatic void add_row(t_in_item it, int reps, bit typed, t_out_item ans);
        t_plan_row row;
        row.it = it;
        row.reps = reps;
        row.typed = typed;
        row.ans = ans;
        plan.push_back(row);
    endfunction

    localparam logic [VAL_W-1:0] ALL_ONES = '1;
    localparam t_out_item        BAD_RANGE = '{best_xor: '0, range_error: 1'b1};
    localparam t_out_item        NO_ANS = '0;

    task automatic build_plan();
        // Query on the empty list right after reset.
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd1, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_APPEND, '0, '0, '0, '0), 1, 1'b0, NO_ANS);
        add_row(make_item(CMD_APPEND, ALL_ONES, '1, '1, ALL_ONES), 1, 1'b0, NO_ANS);
        add_row(make_item(CMD_APPEND, 31'h2AAA_AAAA, '0, '0, '0), 1, 1'b0, NO_ANS);
        // Key zero picks the largest value, key all ones the smallest.
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd3, '0), 1, 1'b1,
                '{best_xor: ALL_ONES, range_error: 1'b0});
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd3, ALL_ONES), 1, 1'b1,
                '{best_xor: ALL_ONES, range_error: 1'b0});
        add_row(make_item(CMD_QUERY, '0, 17'd3, 17'd3, 31'h5555_5555), 1, 1'b0, NO_ANS);
        add_row(make_item(CMD_QUERY, '0, 17'd2, 17'd2, 31'h1234_5678), 1, 1'b0, NO_ANS);
        // Bad ranges: left position zero, left above right, right past count.
        add_row(make_item(CMD_QUERY, '0, 17'd0, 17'd2, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_QUERY, '0, 17'd3, 17'd2, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd4, '0), 1, 1'b1, BAD_RANGE);
        // The unused command must leave the count alone.
        add_row(make_item(t_cmd'(2'd3), ALL_ONES, '1, '1, ALL_ONES), 1, 1'b0, NO_ANS);
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd4, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd3, 31'h0F0F_0F0F), 1, 1'b0, NO_ANS);
        // Clear, then the old contents must be gone.
        add_row(make_item(CMD_CLEAR, ALL_ONES, '1, '1, ALL_ONES), 1, 1'b0, NO_ANS);
        add_row(make_item(CMD_QUERY, '0, 17'd1, 17'd1, '0), 1, 1'b1, BAD_RANGE);
        // Positions at the top of the field are far past the count.
        add_row(make_item(CMD_QUERY, '0, 17'd65536, 17'd65537, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_QUERY, '0, '1, '1, '0), 1, 1'b1, BAD_RANGE);
        add_row(make_item(CMD_CLEAR, '0, '0, '0, '0), 1, 1'b0, NO_ANS);
    endtask

    // Random items keep the list short so that scans stay quick. Most items
    // are appends and well-formed queries; a few are bad ranges, clears and
    // the unused command.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned lo;
        it = make_item(CMD_QUERY, VAL_W'($urandom()), POS_W'($urandom()),
                       POS_W'($urandom()), VAL_W'($urandom()));
        pick = $urandom_range(99);
        if (list_count > 120 && pick < 10) begin
            it.cmd = CMD_CLEAR;
        end else if (pick < 3) begin
            it.cmd = CMD_CLEAR;
        end else if (pick < 6) begin
            it.cmd = t_cmd'(2'd3);
        end else if (pick < 48 || list_count == 0) begin
            it.cmd = CMD_APPEND;
        end else if (pick < 90) begin
            lo = $urandom_range(1, list_count);
            it.left_pos  = POS_W'(lo);
            it.right_pos = POS_W'($urandom_range(lo, list_count));
        end else if (pick < 93) begin
            it.left_pos = '0;
        end else if (pick < 96) begin
            lo = $urandom_range(2, list_count + 2);
            it.left_pos  = POS_W'(lo);
            it.right_pos = POS_W'($urandom_range(1, lo - 1));
        end else begin
            it.left_pos  = POS_W'($urandom_range(1, list_count + 1));
            it.right_pos = POS_W'(list_count + 1 + $urandom_range(0, 3));
        end
        return it;
    endfunction

    // Sender: reset, directed plan, random items, then drain and finish.
    initial begin
        t_in_item it;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_plan();
        foreach (plan[n]) begin
            for (int k = 0; k < plan[n].reps; k++) begin
                it = plan[n].it;
                if (plan[n].reps > 1) it.value = VAL_W'($urandom());
                send_item(it, plan[n].typed, plan[n].ans);
                if (plan[n].reps == 1) maybe_idle_sender();
            end
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_phase = (n >= 400 && n < 650);
            send_item(random_item(), 1'b0, NO_ANS);
            maybe_idle_sender();
        end
        push <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        // No stray answers may follow the last expected one.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: compares each answer with the oldest expectation and drives
    // pop. Once, after some answers have come, it holds off long enough for
    // the block to fill up and stall the input side.
    initial begin
        t_out_item want;
        int        hold_off;
        bit        held;
        hold_off = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (answer_taken) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    $error("answer with nothing expected: best_xor %0h range_error %0b",
                           answer_seen.best_xor, answer_seen.range_error);
                    error_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (answer_seen.best_xor !== want.best_xor) begin
                        $error("best_xor: expected %0h, actual %0h",
                               want.best_xor, answer_seen.best_xor);
                        error_count++;
                    end
                    if (answer_seen.range_error !== want.range_error) begin
                        $error("range_error: expected %0b, actual %0b",
                               want.range_error, answer_seen.range_error);
                        error_count++;
                    end
                end
            end
            if (!held && answers_seen == 60) begin
                held = 1'b1;
                hold_off = 500;
            end
            if (hold_off > 0) begin
                hold_off--;
                pop <= 1'b0;
            end else if (steady_phase) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 7);
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            quiet = (item_taken || answer_taken || !i_rst_n) ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end
endmodule
